// File: src/hebp_pkg.sv
package hebp_pkg;

	localparam int TABLE_DEPTH_DEF = 512;
	localparam int CODE_W = 16;
	localparam int LEN_W = 5;
	localparam int ENTRY_W = CODE_W + LEN_W;
	localparam int MAX_LEN = 16;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_ENCODE = 2'd1,
		MODE_FLUSH = 2'd2
	} mode_t;

endpackage

// File: src/huffman_encode_bit_packer_unit.sv
// Table-driven Huffman encoder packing code bits MSB first into bytes.
// The item channel (sym_valid, sym_stall) carries mode, symbol, code_value and
// code_length. A load transfer writes one code-table entry, an encode transfer
// looks up the entry of its symbol and appends the code bits below the pending
// bits, and a flush transfer emits the partial byte padded with zeros.
// The byte channel (byte_valid, byte_stall) carries out_byte and last; last
// marks the final byte that one item produced.
// An item is accepted and the code table RAM is read at that edge; the packer
// stage consumes the item once the output queue has room for its bytes, placing
// them in a two-entry output queue. The first byte is offered once it is written
// into the queue and transfers at an edge where byte_stall is low.
// One item is accepted per cycle while each produces at most one byte and the
// receiver does not stall; items producing two bytes are limited by the single
// byte port, which drains one byte per cycle.
// A stalled receiver fills the output queue, after which sym_stall rises and
// holds the packer stage. Reset clears the pending bits and the queue; the code
// table is not cleared, so each symbol must be loaded before it is encoded.
module huffman_encode_bit_packer_unit import hebp_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sym_valid,
	output logic              sym_stall,
	input  logic [1:0]        mode,
	input  logic signed [8:0] symbol,
	input  logic [15:0]       code_value,
	input  logic [4:0]        code_length,
	output logic              byte_valid,
	input  logic              byte_stall,
	output logic [7:0]        out_byte,
	output logic              last
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int OFFSET = TABLE_DEPTH / 2 + TABLE_DEPTH * ((256 + TABLE_DEPTH - 1) / TABLE_DEPTH);
	localparam logic [AW:0] DEPTH_V = (AW + 1)'(TABLE_DEPTH);

	logic [AW-1:0] hi_tab [16];
	logic [AW-1:0] lo_tab [32];

	for (genvar i = 0; i < 16; i++) begin : g_hi
		localparam int HI = (i < 8) ? i : i - 16;
		localparam int HV = (HI * 32 + OFFSET) % TABLE_DEPTH;
		assign hi_tab[i] = AW'(HV);
	end

	for (genvar j = 0; j < 32; j++) begin : g_lo
		localparam int LV = j % TABLE_DEPTH;
		assign lo_tab[j] = AW'(LV);
	end

	logic [AW:0]   slot_sum;
	logic [AW-1:0] slot;
	logic          accept;

	always_comb begin
		slot_sum = {1'b0, hi_tab[symbol[8:5]]} + {1'b0, lo_tab[symbol[4:0]]};
		if (slot_sum >= DEPTH_V) begin
			slot = AW'(slot_sum - DEPTH_V);
		end else begin
			slot = slot_sum[AW-1:0];
		end
	end

	logic [ENTRY_W-1:0] code_mem [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rdata_s1;
	logic [1:0]         mode_s1;
	logic               valid_s1;

	always_ff @(posedge clk) begin
		if (accept && mode == MODE_LOAD) begin
			code_mem[slot] <= {code_value, code_length};
		end
		if (accept && mode == MODE_ENCODE) begin
			rdata_s1 <= code_mem[slot];
		end
		if (accept) begin
			mode_s1 <= mode;
		end
	end

	logic [7:0]  acc_q;
	logic [2:0]  pend_q;
	logic [7:0]  obyte_q [2];
	logic        olast_q [2];
	logic [1:0]  ocnt_q;

	logic [4:0]  len_sat;
	logic [15:0] code_m;
	logic [23:0] placed;
	logic [23:0] full;
	logic [4:0]  total;
	logic [1:0]  res_n;
	logic [7:0]  res_byte0;
	logic [7:0]  res_byte1;
	logic        res_last0;
	logic [7:0]  acc_next;
	logic [2:0]  pend_next;
	logic        pop;
	logic [1:0]  rem;
	logic        fire;

	always_comb begin
		len_sat = (rdata_s1[LEN_W-1:0] > 5'(MAX_LEN)) ? 5'(MAX_LEN) : rdata_s1[LEN_W-1:0];
		code_m = rdata_s1[ENTRY_W-1:LEN_W] & ~(16'hFFFF >> len_sat);
		placed = {code_m, 8'h00} >> pend_q;
		full = {acc_q, 16'h0000} | placed;
		total = 5'(pend_q) + len_sat;
		res_n = 2'd0;
		res_byte0 = full[23:16];
		res_byte1 = full[15:8];
		res_last0 = 1'b1;
		acc_next = acc_q;
		pend_next = pend_q;
		unique case (mode_s1)
			MODE_ENCODE: begin
				res_n = total[4:3];
				res_last0 = (total[4:3] == 2'd1);
				pend_next = total[2:0];
				unique case (total[4:3])
					2'd0: acc_next = full[23:16];
					2'd1: acc_next = full[15:8];
					2'd2: acc_next = full[7:0];
					default: acc_next = full[7:0];
				endcase
			end
			MODE_FLUSH: begin
				res_n = (pend_q != 3'd0) ? 2'd1 : 2'd0;
				res_byte0 = acc_q;
				acc_next = 8'h00;
				pend_next = 3'd0;
			end
			default: begin
				res_n = 2'd0;
			end
		endcase
	end

	assign byte_valid = (ocnt_q != 2'd0);
	assign out_byte = obyte_q[0];
	assign last = olast_q[0];
	assign pop = byte_valid && !byte_stall;
	assign rem = ocnt_q - {1'b0, pop};
	assign fire = valid_s1 && (({1'b0, rem} + {1'b0, res_n}) <= 3'd2);
	assign sym_stall = valid_s1 && !fire;
	assign accept = sym_valid && !sym_stall;

	logic [7:0] nbyte [2];
	logic       nlast [2];

	always_comb begin
		nbyte[0] = pop ? obyte_q[1] : obyte_q[0];
		nlast[0] = pop ? olast_q[1] : olast_q[0];
		nbyte[1] = obyte_q[1];
		nlast[1] = olast_q[1];
		if (fire && res_n != 2'd0) begin
			nbyte[rem[0]] = res_byte0;
			nlast[rem[0]] = res_last0;
		end
		if (fire && res_n == 2'd2) begin
			nbyte[1] = res_byte1;
			nlast[1] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		obyte_q[0] <= nbyte[0];
		obyte_q[1] <= nbyte[1];
		olast_q[0] <= nlast[0];
		olast_q[1] <= nlast[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q <= 8'h00;
			pend_q <= 3'd0;
			ocnt_q <= 2'd0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				acc_q <= acc_next;
				pend_q <= pend_next;
				ocnt_q <= rem + res_n;
			end else begin
				ocnt_q <= rem;
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) !fire |=> $stable(pend_q) && $stable(acc_q))
		else $error("Packer state changed without a packer transfer.");
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode_s1 == MODE_FLUSH |=> pend_q == 3'd0 && acc_q == 8'h00)
		else $error("Flush did not clear the packer.");
	assert property (@(posedge clk) disable iff (!arst_n) sym_stall |-> valid_s1 && ocnt_q != 2'd0)
		else $error("Item channel stalled while the output queue had room.");
	assert property (@(posedge clk) disable iff (!arst_n) (acc_q & (8'hFF >> pend_q)) == 8'h00)
		else $error("Accumulator holds bits below the pending count.");
`endif

endmodule
